>>> design/tftp_packet_parser_unit_assert.svh
// Assertion macros for the TFTP parser RTL.
`ifndef TFTP_PACKET_PARSER_UNIT_ASSERT_SVH
`define TFTP_PACKET_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define TFPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define TFPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tfpp_pkg.sv
`default_nettype none

package tfpp_pkg;

  // Most results that a single byte can cause.
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChNul = 8'h00;

  localparam logic [15:0] OpRrq   = 16'd1;
  localparam logic [15:0] OpWrq   = 16'd2;
  localparam logic [15:0] OpData  = 16'd3;
  localparam logic [15:0] OpAck   = 16'd4;
  localparam logic [15:0] OpError = 16'd5;

  localparam logic [1:0] FldName = 2'd0;
  localparam logic [1:0] FldMode = 2'd1;
  localparam logic [1:0] FldData = 2'd2;
  localparam logic [1:0] FldMsg  = 2'd3;

  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StTooShort    = 2'd1;
  localparam logic [1:0] StIllegalOpc  = 2'd2;
  localparam logic [1:0] StIllegalMode = 2'd3;

  localparam logic KindByte    = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic ModeNetascii = 1'b0;
  localparam logic ModeOctet    = 1'b1;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [1:0]  field_id;
    logic [7:0]  out_byte;
    logic [2:0]  packet_kind;
    logic [15:0] number_field;
    logic        transfer_mode;
    logic [1:0]  status;
  } res_t;

  function automatic logic [7:0] netascii_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6E; // n
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h73; // s
      3'd5:    c = 8'h63; // c
      3'd6:    c = 8'h69; // i
      default: c = 8'h69; // i
    endcase
    return c;
  endfunction

  function automatic logic [7:0] octet_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6F; // o
      3'd1:    c = 8'h63; // c
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h65; // e
      3'd4:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/tftp_packet_parser_unit.sv
// TFTP receive-side parser. Packet bytes enter one per request on the input
// channel, with end_of_packet_i high on the final byte. The parser reads the
// opcode, the block number or error code, netascii-decodes filename and error
// message text (CR LF becomes LF, CR NUL becomes CR), forwards mode text and
// data payload bytes unchanged, and closes every packet with a summary request
// that carries the packet kind, number, transfer mode and status. Each input
// byte causes zero to three output requests, the last of them flagged by
// last_o. A byte is parsed in the cycle it is accepted and its results land
// in a three-entry result register, which drains one request per cycle while
// out_ready_i is high; a new byte is taken as soon as at most one result of
// the previous byte is still waiting and that one is leaving. No clearing
// pass is needed after reset.

`default_nettype none

module tftp_packet_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_packet_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [1:0]       field_id_o,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       packet_kind_o,
  output logic [15:0]      number_field_o,
  output logic             transfer_mode_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

`include "tftp_packet_parser_unit_assert.svh"

  // The result register holds the results of one byte at a time; entry 0 is
  // the one on the output port.
  tfpp_pkg::res_t res    [tfpp_pkg::MaxResults];
  logic [1:0]     res_cnt;
  tfpp_pkg::res_t slot_q [tfpp_pkg::MaxResults];
  logic [1:0]     cnt_q;
  logic           fire;
  logic           pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // Accept when the register is empty or its last entry leaves this cycle.
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign fire        = in_valid_i && in_ready_o;

  tfpp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (in_byte_i),
    .eop_i     (end_of_packet_i),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (fire) begin
      cnt_q <= res_cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Payload entries carry no reset; the count says which are meaningful.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < tfpp_pkg::MaxResults; i++) begin
        slot_q[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < tfpp_pkg::MaxResults - 1; i++) begin
        slot_q[i] <= slot_q[i + 1];
      end
    end
  end

  assign kind_o          = slot_q[0].kind;
  assign field_id_o      = slot_q[0].field_id;
  assign out_byte_o      = slot_q[0].out_byte;
  assign packet_kind_o   = slot_q[0].packet_kind;
  assign number_field_o  = slot_q[0].number_field;
  assign transfer_mode_o = slot_q[0].transfer_mode;
  assign status_o        = slot_q[0].status;
  // Only one byte's results are held, so the final waiting entry is its last.
  assign last_o          = (cnt_q == 2'd1);

  // A stalled result neither moves nor changes.
  `TFPP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(cnt_q) && $stable(slot_q[0]), "result changed while stalled")

  // A summary always closes the results of its byte.
  `TFPP_ASSERT_SAME(a_summary_last, clk_i, rst_ni,
    out_valid_o && (kind_o == tfpp_pkg::KindSummary), last_o,
    "summary not flagged as last")

  // A final packet byte always yields at least its summary.
  `TFPP_ASSERT_SAME(a_eop_summary, clk_i, rst_ni, fire && end_of_packet_i,
    res_cnt != 2'd0, "end of packet without summary")

endmodule

`default_nettype wire

>>> design/tfpp_parser.sv
`default_nettype none

// Per-byte parse state and the results that one accepted byte causes.
module tfpp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            eop_i,
  output tfpp_pkg::res_t       res_o [tfpp_pkg::MaxResults],
  output logic [1:0]           res_cnt_o
);

  typedef enum logic [2:0] {
    PH_OPC_HI, PH_OPC_LO, PH_NAME, PH_MODE,
    PH_NUMBER, PH_PAYLOAD, PH_MESSAGE, PH_IGNORE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] opc_q, opc_d;
  logic [15:0] num_q, num_d;
  logic [1:0]  hdr_q, hdr_d;
  logic        cr_q, cr_d;
  logic [3:0]  midx_q, midx_d;
  logic [1:0]  mm_q, mm_d;

  logic [1:0]  n;
  logic [1:0]  fid;
  logic        pass;
  logic [7:0]  lb;
  logic [1:0]  hc;
  tfpp_pkg::res_t sum;

  always_comb begin
    phase_d = phase_q;
    opc_d   = opc_q;
    num_d   = num_q;
    hdr_d   = hdr_q;
    cr_d    = cr_q;
    midx_d  = midx_q;
    mm_d    = mm_q;
    n       = 2'd0;
    fid     = tfpp_pkg::FldName;
    pass    = 1'b1;
    lb      = in_byte_i;
    hc      = hdr_q + 2'd1;
    sum     = '0;
    for (int i = 0; i < tfpp_pkg::MaxResults; i++) begin
      res_o[i] = '0;
    end

    case (phase_q)
      PH_OPC_HI: begin
        opc_d   = {8'h00, in_byte_i};
        phase_d = PH_OPC_LO;
      end
      PH_OPC_LO: begin
        opc_d = {opc_q[7:0], in_byte_i};
        if (opc_d inside {tfpp_pkg::OpRrq, tfpp_pkg::OpWrq}) begin
          phase_d = PH_NAME;
        end else if (opc_d inside {[tfpp_pkg::OpData:tfpp_pkg::OpError]}) begin
          phase_d = PH_NUMBER;
        end else begin
          phase_d = PH_IGNORE;
        end
      end
      PH_NAME, PH_MESSAGE: begin
        fid = (phase_q == PH_NAME) ? tfpp_pkg::FldName : tfpp_pkg::FldMsg;
        // A held CR is resolved first: CR LF gives LF, CR NUL gives CR.
        if (cr_q) begin
          cr_d = 1'b0;
          res_o[n].field_id = fid;
          if (in_byte_i == tfpp_pkg::ChLf) begin
            res_o[n].out_byte = tfpp_pkg::ChLf;
            pass = 1'b0;
          end else begin
            res_o[n].out_byte = tfpp_pkg::ChCr;
            pass = (in_byte_i != tfpp_pkg::ChNul);
          end
          n = n + 2'd1;
        end
        if (pass) begin
          if (in_byte_i == tfpp_pkg::ChNul) begin
            phase_d = (phase_q == PH_NAME) ? PH_MODE : PH_IGNORE;
          end else if (in_byte_i == tfpp_pkg::ChCr && !eop_i) begin
            cr_d = 1'b1;
          end else begin
            res_o[n].field_id = fid;
            res_o[n].out_byte = in_byte_i;
            n = n + 2'd1;
          end
        end
      end
      PH_MODE: begin
        if (in_byte_i == tfpp_pkg::ChNul) begin
          phase_d = PH_IGNORE;
        end else begin
          res_o[n].field_id = tfpp_pkg::FldMode;
          res_o[n].out_byte = in_byte_i;
          n = n + 2'd1;
          if (in_byte_i inside {[8'h41:8'h5A]}) begin
            lb = in_byte_i + 8'd32;
          end
          if (midx_q >= 4'd8 || lb != tfpp_pkg::netascii_char(midx_q[2:0])) begin
            mm_d[0] = 1'b0;
          end
          if (midx_q >= 4'd5 || lb != tfpp_pkg::octet_char(midx_q[2:0])) begin
            mm_d[1] = 1'b0;
          end
          if (midx_q != 4'd15) begin
            midx_d = midx_q + 4'd1;
          end
        end
      end
      PH_NUMBER: begin
        num_d = {num_q[7:0], in_byte_i};
        hdr_d = hc;
        if (hc[1]) begin
          if (opc_q == tfpp_pkg::OpData) begin
            phase_d = PH_PAYLOAD;
          end else if (opc_q == tfpp_pkg::OpError) begin
            phase_d = PH_MESSAGE;
          end else begin
            phase_d = PH_IGNORE;
          end
        end
      end
      PH_PAYLOAD: begin
        res_o[n].field_id = tfpp_pkg::FldData;
        res_o[n].out_byte = in_byte_i;
        n = n + 2'd1;
      end
      default: begin
      end
    endcase

    if (eop_i) begin
      sum.kind = tfpp_pkg::KindSummary;
      if (phase_d inside {PH_OPC_HI, PH_OPC_LO}) begin
        sum.status = tfpp_pkg::StTooShort;
      end else if (!(opc_d inside {[tfpp_pkg::OpRrq:tfpp_pkg::OpError]})) begin
        sum.status = tfpp_pkg::StIllegalOpc;
      end else begin
        sum.packet_kind = opc_d[2:0] - 3'd1;
        if (opc_d <= tfpp_pkg::OpWrq) begin
          if (mm_d[0] && midx_d == 4'd8) begin
            sum.transfer_mode = tfpp_pkg::ModeNetascii;
          end else if (mm_d[1] && midx_d == 4'd5) begin
            sum.transfer_mode = tfpp_pkg::ModeOctet;
          end else begin
            sum.status = tfpp_pkg::StIllegalMode;
          end
        end else if (phase_d == PH_NUMBER) begin
          sum.status = tfpp_pkg::StTooShort;
        end else begin
          sum.number_field = num_d;
        end
      end
      res_o[n] = sum;
      n = n + 2'd1;
      // The packet is over: all parse state returns to its reset values.
      phase_d = PH_OPC_HI;
      opc_d   = '0;
      num_d   = '0;
      hdr_d   = '0;
      cr_d    = 1'b0;
      midx_d  = '0;
      mm_d    = 2'b11;
    end
    res_cnt_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPC_HI;
      opc_q   <= '0;
      num_q   <= '0;
      hdr_q   <= '0;
      cr_q    <= 1'b0;
      midx_q  <= '0;
      mm_q    <= 2'b11;
    end else if (fire_i) begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      num_q   <= num_d;
      hdr_q   <= hdr_d;
      cr_q    <= cr_d;
      midx_q  <= midx_d;
      mm_q    <= mm_d;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_tftp_packet_parser_unit.sv
`default_nettype none

module tb_tftp_packet_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The receiver counts its own cycles after reset to place its
  // long hold-off and its calm stretch. The sender's calm stretch is counted
  // in random bytes. The random part adds to the directed table to make
  // about 170 bytes in all.
  localparam int unsigned RandomItems = 143;
  localparam int unsigned QuietLimit  = 500;
  localparam int unsigned HoldAt      = 120;
  localparam int unsigned HoldLen     = 60;
  localparam int unsigned CalmFrom    = 40;
  localparam int unsigned CalmTo      = 115;
  localparam int unsigned DrainCycles = 8;

  localparam logic [2:0] PkRrq   = 3'd0;
  localparam logic [2:0] PkWrq   = 3'd1;
  localparam logic [2:0] PkData  = 3'd2;
  localparam logic [2:0] PkAck   = 3'd3;

  // Mode words, with the first letter in the highest used byte.
  localparam logic [63:0] NetasciiTxt = "netascii";
  localparam logic [63:0] OctetTxt    = "octet";

  typedef enum logic [2:0] {
    PhOpcHi, PhOpcLo, PhName, PhMode, PhNumber, PhPayload, PhMessage, PhIgnore
  } parse_phase_e;

  // One output request together with its last flag.
  typedef struct packed {
    tfpp_pkg::res_t r;
    logic           last;
  } parsed_t;

  // One row of the directed table. A row with typed set carries the summary
  // that its byte must produce; every other row is left to the predictor.
  typedef struct packed {
    logic [7:0]     data;
    logic           eop;
    logic           typed;
    tfpp_pkg::res_t sum;
  } dir_row_t;

  // Summaries in field order: kind, field, byte, packet kind, number, mode,
  // status.
  localparam tfpp_pkg::res_t NoSum = '0;
  localparam tfpp_pkg::res_t SumTooShort =
    '{tfpp_pkg::KindSummary, tfpp_pkg::FldName, 8'h00, PkRrq, 16'h0000,
      tfpp_pkg::ModeNetascii, tfpp_pkg::StTooShort};
  localparam tfpp_pkg::res_t SumIllegalOpc =
    '{tfpp_pkg::KindSummary, tfpp_pkg::FldName, 8'h00, PkRrq, 16'h0000,
      tfpp_pkg::ModeNetascii, tfpp_pkg::StIllegalOpc};
  localparam tfpp_pkg::res_t SumDataShort =
    '{tfpp_pkg::KindSummary, tfpp_pkg::FldName, 8'h00, PkData, 16'h0000,
      tfpp_pkg::ModeNetascii, tfpp_pkg::StTooShort};
  localparam tfpp_pkg::res_t SumAckTop =
    '{tfpp_pkg::KindSummary, tfpp_pkg::FldName, 8'h00, PkAck, 16'hFFFF,
      tfpp_pkg::ModeNetascii, tfpp_pkg::StOk};
  localparam tfpp_pkg::res_t SumWrqBadMode =
    '{tfpp_pkg::KindSummary, tfpp_pkg::FldName, 8'h00, PkWrq, 16'h0000,
      tfpp_pkg::ModeNetascii, tfpp_pkg::StIllegalMode};

  localparam int unsigned DirCount = 27;
  localparam dir_row_t DirectedRows [DirCount] = '{
    // A lone byte ends the packet inside the opcode.
    '{8'h00, 1'b1, 1'b1, SumTooShort},
    // The largest opcode is illegal.
    '{8'hFF, 1'b0, 1'b0, NoSum},
    '{8'hFF, 1'b1, 1'b1, SumIllegalOpc},
    // A DATA packet that ends inside its block number.
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h03, 1'b0, 1'b0, NoSum},
    '{8'h12, 1'b1, 1'b1, SumDataShort},
    // An ACK of the top block number; the byte after the number is ignored.
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h04, 1'b0, 1'b0, NoSum},
    '{8'hFF, 1'b0, 1'b0, NoSum},
    '{8'hFF, 1'b0, 1'b0, NoSum},
    '{8'h55, 1'b1, 1'b1, SumAckTop},
    // An ERROR with code zero. The message holds CR LF, CR NUL, a CR before
    // a plain letter, and a CR on the final byte.
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h05, 1'b0, 1'b0, NoSum},
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h0D, 1'b0, 1'b0, NoSum},
    '{8'h0A, 1'b0, 1'b0, NoSum},
    '{8'h0D, 1'b0, 1'b0, NoSum},
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h0D, 1'b0, 1'b0, NoSum},
    '{8'h41, 1'b0, 1'b0, NoSum},
    '{8'h0D, 1'b1, 1'b0, NoSum},
    // A read request whose only filename byte is the last one: empty mode.
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h01, 1'b0, 1'b0, NoSum},
    '{8'hFF, 1'b1, 1'b0, NoSum},
    // A write request that stops right after its opcode.
    '{8'h00, 1'b0, 1'b0, NoSum},
    '{8'h02, 1'b1, 1'b1, SumWrqBadMode}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        end_of_packet_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        kind_o;
  logic [1:0]  field_id_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  packet_kind_o;
  logic [15:0] number_field_o;
  logic        transfer_mode_o;
  logic [1:0]  status_o;
  logic        last_o;

  // Travel with the input request so that the scoreboard knows whether a
  // typed summary replaces the prediction.
  logic           row_typed;
  tfpp_pkg::res_t row_sum;

  tftp_packet_parser_unit DUT (.*);

  // Parser state as the predictor keeps it.
  parse_phase_e ph;
  logic [15:0]  opc;
  logic [15:0]  num;
  logic [1:0]   hdr_cnt;
  logic         cr_hold;
  logic [3:0]   mode_cnt;
  logic [1:0]   mode_ok;

  parsed_t     step_res[$];
  parsed_t     results_due[$];
  logic [7:0]  packet_bytes[$];

  int unsigned errors;
  int unsigned bytes_in;
  int unsigned results_checked;
  int unsigned summaries [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Appends at the tail of the three queues.
  function automatic void queue_step(input parsed_t p);
    step_res.insert(step_res.size(), p);
  endfunction

  function automatic void queue_due(input parsed_t p);
    results_due.insert(results_due.size(), p);
  endfunction

  function automatic void queue_pkt(input logic [7:0] b);
    packet_bytes.insert(packet_bytes.size(), b);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------

  task automatic clear_parser();
    ph       = PhOpcHi;
    opc      = '0;
    num      = '0;
    hdr_cnt  = '0;
    cr_hold  = 1'b0;
    mode_cnt = '0;
    mode_ok  = 2'b11;
  endtask

  task automatic emit_byte(input logic [1:0] fld, input logic [7:0] b);
    parsed_t p;
    p            = '0;
    p.r.kind     = tfpp_pkg::KindByte;
    p.r.field_id = fld;
    p.r.out_byte = b;
    p.r.status   = tfpp_pkg::StOk;
    queue_step(p);
  endtask

  // Netascii decoding with a held CR. A held CR is always released by the
  // next byte: LF turns it into LF, NUL turns it into CR and is consumed,
  // and anything else lets the CR out before the byte is handled normally.
  task automatic decode_text(input logic [1:0] fld, input logic [7:0] b,
                             input logic eop, output logic done);
    done = 1'b0;
    if (cr_hold) begin
      cr_hold = 1'b0;
      if (b inside {tfpp_pkg::ChLf, tfpp_pkg::ChNul}) begin
        emit_byte(fld, (b == tfpp_pkg::ChLf) ? tfpp_pkg::ChLf : tfpp_pkg::ChCr);
        return;
      end
      emit_byte(fld, tfpp_pkg::ChCr);
    end
    if (b == tfpp_pkg::ChNul) begin
      done = 1'b1;
    end else if (b == tfpp_pkg::ChCr && !eop) begin
      cr_hold = 1'b1;
    end else begin
      emit_byte(fld, b);
    end
  endtask

  // Case-blind comparison of one mode byte with both mode words; only the
  // letters A to Z fold.
  task automatic match_mode(input logic [7:0] b);
    logic [7:0] lc;
    int         idx;
    lc  = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    idx = mode_cnt;
    if (idx >= 8 || lc != NetasciiTxt[8*(7-idx) +: 8]) mode_ok[0] = 1'b0;
    if (idx >= 5 || lc != OctetTxt[8*(4-idx) +: 8]) mode_ok[1] = 1'b0;
    if (mode_cnt < 4'd15) mode_cnt = mode_cnt + 4'd1;
  endtask

  // Works out every request that one accepted byte causes, into step_res.
  task automatic parse_byte(input logic [7:0] b, input logic eop);
    logic    done;
    parsed_t s;
    done = 1'b0;
    step_res.delete();
    case (ph)
      PhOpcHi: begin
        opc = {8'h00, b};
        ph  = PhOpcLo;
      end
      PhOpcLo: begin
        opc = {opc[7:0], b};
        if (opc inside {tfpp_pkg::OpRrq, tfpp_pkg::OpWrq}) ph = PhName;
        else if (opc inside {[tfpp_pkg::OpData:tfpp_pkg::OpError]}) ph = PhNumber;
        else ph = PhIgnore;
      end
      PhName: begin
        decode_text(tfpp_pkg::FldName, b, eop, done);
        if (done) ph = PhMode;
      end
      PhMode: begin
        // Mode text goes out raw; its NUL ends the request body.
        if (b == tfpp_pkg::ChNul) begin
          ph = PhIgnore;
        end else begin
          emit_byte(tfpp_pkg::FldMode, b);
          match_mode(b);
        end
      end
      PhNumber: begin
        num     = {num[7:0], b};
        hdr_cnt = hdr_cnt + 2'd1;
        if (hdr_cnt >= 2'd2) begin
          if (opc == tfpp_pkg::OpData) ph = PhPayload;
          else if (opc == tfpp_pkg::OpError) ph = PhMessage;
          else ph = PhIgnore;
        end
      end
      PhPayload: emit_byte(tfpp_pkg::FldData, b);
      PhMessage: begin
        decode_text(tfpp_pkg::FldMsg, b, eop, done);
        if (done) ph = PhIgnore;
      end
      default: ;
    endcase

    if (eop) begin
      s                 = '0;
      s.r.kind          = tfpp_pkg::KindSummary;
      s.r.field_id      = tfpp_pkg::FldName;
      s.r.transfer_mode = tfpp_pkg::ModeNetascii;
      s.r.status        = tfpp_pkg::StOk;
      if (ph inside {PhOpcHi, PhOpcLo}) begin
        s.r.status = tfpp_pkg::StTooShort;
      end else if (!(opc inside {[tfpp_pkg::OpRrq:tfpp_pkg::OpError]})) begin
        s.r.status = tfpp_pkg::StIllegalOpc;
      end else begin
        s.r.packet_kind = opc[2:0] - 3'd1;
        if (opc <= tfpp_pkg::OpWrq) begin
          // The mode read so far must be one whole word.
          if (mode_ok[0] && mode_cnt == 4'd8) begin
            s.r.transfer_mode = tfpp_pkg::ModeNetascii;
          end else if (mode_ok[1] && mode_cnt == 4'd5) begin
            s.r.transfer_mode = tfpp_pkg::ModeOctet;
          end else begin
            s.r.status = tfpp_pkg::StIllegalMode;
          end
        end else if (ph == PhNumber) begin
          s.r.status = tfpp_pkg::StTooShort;
        end else begin
          s.r.number_field = num;
        end
      end
      queue_step(s);
      clear_parser();
    end

    if (step_res.size() > 0) begin
      s      = step_res.pop_back();
      s.last = 1'b1;
      queue_step(s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, before any
  // driver updates land, so the order of processes within a step does not
  // matter. Input requests are predicted before results are checked.
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    parsed_t got;
    parsed_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      parse_byte(in_byte_i, end_of_packet_i);
      if (row_typed) begin
        want.r    = row_sum;
        want.last = 1'b1;
        queue_due(want);
      end else begin
        foreach (step_res[i]) queue_due(step_res[i]);
      end
      bytes_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.r    = '{kind_o, field_id_o, out_byte_o, packet_kind_o, number_field_o,
                   transfer_mode_o, status_o};
      got.last = last_o;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = results_due.pop_front();
        check_field("kind", 16'(want.r.kind), 16'(got.r.kind));
        check_field("field_id", 16'(want.r.field_id), 16'(got.r.field_id));
        check_field("out_byte", 16'(want.r.out_byte), 16'(got.r.out_byte));
        check_field("packet_kind", 16'(want.r.packet_kind), 16'(got.r.packet_kind));
        check_field("number_field", want.r.number_field, got.r.number_field);
        check_field("transfer_mode", 16'(want.r.transfer_mode),
                    16'(got.r.transfer_mode));
        check_field("status", 16'(want.r.status), 16'(got.r.status));
        check_field("last", 16'(want.last), 16'(got.last));
        results_checked++;
        if (want.r.kind == tfpp_pkg::KindSummary) summaries[want.r.status]++;
      end
    end
  end

  // Ends the run when neither channel has moved a request for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no request moved for %0d cycles", $time, QuietLimit);
    $display("tb_tftp_packet_parser_unit: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side. It stalls at random, once holds off long enough for the
  // parser to fill up and stall its input, and has a stretch of steady
  // acceptance.
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == HoldAt) begin
        out_ready_i <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
      end else if (cyc >= CalmFrom && cyc < CalmTo) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Byte side.
  // ---------------------------------------------------------------------

  // Offers one byte, after an occasional one-cycle gap, and returns at the
  // edge that takes it. Valid stays high from one byte to the next unless a
  // gap falls.
  task automatic send_byte(input logic [7:0] b, input logic eop, input logic typed,
                           input tfpp_pkg::res_t sum, input bit steady);
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_packet_i <= eop;
    row_typed       <= typed;
    row_sum         <= sum;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Filename or message text, rich in CR, LF and CR NUL, never a bare NUL.
  task automatic add_text();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: queue_pkt(tfpp_pkg::ChCr);
        2: queue_pkt(tfpp_pkg::ChLf);
        3: begin
          queue_pkt(tfpp_pkg::ChCr);
          queue_pkt(tfpp_pkg::ChNul);
        end
        default: queue_pkt(8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  // The first keep letters of a mode word, each in random case.
  task automatic add_word(input logic [63:0] w, input int len, input int keep);
    logic [7:0] c;
    for (int i = 0; i < keep; i++) begin
      c = w[8*(len-1-i) +: 8];
      if ($urandom_range(0, 1) == 1) c = c - 8'd32;
      queue_pkt(c);
    end
  endtask

  // Bytes past a terminator, which the parser drops.
  task automatic add_tail();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) queue_pkt(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets with random content; some are cut short and
  // a few are plain noise.
  task automatic build_random_packet();
    logic [15:0] op;
    int          keep;
    packet_bytes.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 5)) queue_pkt(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) packet_bytes[0] = tfpp_pkg::ChNul;
    end else begin
      op = 16'($urandom_range(1, 5));
      queue_pkt(op[15:8]);
      queue_pkt(op[7:0]);
      if (op inside {tfpp_pkg::OpRrq, tfpp_pkg::OpWrq}) begin
        add_text();
        queue_pkt(tfpp_pkg::ChNul);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: add_word(NetasciiTxt, 8, 8);
          4, 5, 6, 7: add_word(OctetTxt, 5, 5);
          8: begin
            // A prefix of a mode word, possibly empty.
            if ($urandom_range(0, 1) == 1) add_word(NetasciiTxt, 8, $urandom_range(0, 7));
            else add_word(OctetTxt, 5, $urandom_range(0, 4));
          end
          default: begin
            // Junk, sometimes long enough to saturate the mode length.
            repeat ($urandom_range(1, 18)) queue_pkt(8'($urandom_range(1, 255)));
          end
        endcase
        queue_pkt(tfpp_pkg::ChNul);
        add_tail();
      end else begin
        queue_pkt(8'($urandom_range(0, 255)));
        queue_pkt(8'($urandom_range(0, 255)));
        if (op == tfpp_pkg::OpData) begin
          repeat ($urandom_range(0, 8)) queue_pkt(8'($urandom_range(0, 255)));
        end else if (op == tfpp_pkg::OpError) begin
          add_text();
          queue_pkt(tfpp_pkg::ChNul);
          add_tail();
        end else begin
          add_tail();
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        keep = $urandom_range(1, packet_bytes.size() - 1);
        while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned fed;
    int          sz;
    errors          = 0;
    bytes_in        = 0;
    results_checked = 0;
    summaries       = '{default: 0};
    clear_parser();
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_byte_i       <= 8'h00;
    end_of_packet_i <= 1'b0;
    row_typed       <= 1'b0;
    row_sum         <= NoSum;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < DirCount; i++) begin
      send_byte(DirectedRows[i].data, DirectedRows[i].eop, DirectedRows[i].typed,
                DirectedRows[i].sum, 1'b0);
    end

    // Random packets. Random bytes 60 to 109 go out with no gaps at all.
    fed = 0;
    while (fed < RandomItems) begin
      build_random_packet();
      sz = packet_bytes.size();
      foreach (packet_bytes[i]) begin
        send_byte(packet_bytes[i], i == sz - 1, 1'b0, NoSum,
                  (fed + i >= 60) && (fed + i < 110));
      end
      fed += unsigned'(sz);
    end
    in_valid_i <= 1'b0;

    // Let every expected request arrive, then watch a little longer for
    // strays.
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, results_due.size());
    end

    $display("Fed %0d packet bytes (%0d from the directed table), checked %0d results.",
             bytes_in, DirCount, results_checked);
    $display("Packet summaries: %0d ok, %0d too short, %0d bad opcode, %0d bad mode.",
             summaries[tfpp_pkg::StOk], summaries[tfpp_pkg::StTooShort],
             summaries[tfpp_pkg::StIllegalOpc], summaries[tfpp_pkg::StIllegalMode]);
    if (errors == 0) begin
      $display("tb_tftp_packet_parser_unit: done, clean");
    end else begin
      $display("tb_tftp_packet_parser_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> tftp_packet_parser_unit.f
+incdir+design
design/tfpp_pkg.sv
design/tfpp_parser.sv
design/tftp_packet_parser_unit.sv
verif/tb_tftp_packet_parser_unit.sv
